// ----- rtl/core/slle_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and codes for the static linked list engine.
package slle_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 10;

  localparam logic [SLOT_W-1:0] FREE_HEAD = '0;
  localparam logic [SLOT_W-1:0] LIST_HEAD = SLOT_W'(SLOTS - 1);
  localparam logic [SLOT_W-1:0] LAST_DATA = SLOT_W'(SLOTS - 2);
  localparam logic [SLOT_W-1:0] FIRST_DATA = SLOT_W'(1);

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] new_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        list_length;
  } out_rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_INS_B,
    S_INS_C,
    S_DEL_B,
    S_DEL_C,
    S_RESULT
  } ctrl_state_t;

  // Link store read address select
  typedef enum logic [1:0] {
    LRD_NONE,
    LRD_HEAD,
    LRD_NEXT,
    LRD_FRESH
  } lrd_sel_t;

  // Link store write select
  typedef enum logic [2:0] {
    LWR_NONE,
    LWR_CLEAR,
    LWR_FRESH,
    LWR_PREV_FRESH,
    LWR_PREV_SKIP,
    LWR_GONE
  } lwr_sel_t;

  typedef struct packed {
    logic       load_req;
    lrd_sel_t   lrd;
    logic       walk_adv;
    logic       walk_cap;
    logic       val_wr;
    logic       val_rd;
    logic       take_fresh;
    logic       free_pop;
    logic       free_push;
    lwr_sel_t   lwr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       out_load;
    logic [1:0] out_status;
  } slle_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       walk_done;
    logic       free_empty;
    logic       ins_ok;
    logic       acc_ok;
    logic       out_busy;
    logic [1:0] in_op;
    logic [1:0] req_op;
  } slle_sts_t;

endpackage

// ----- rtl/core/slle_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the static linked list engine.
module slle_ctrl
  import slle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  slle_sts_t sts,
  output slle_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [1:0]  status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.lrd    = LRD_NONE;
    cmd.lwr    = LWR_NONE;
    cmd.out_status = status_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.lwr = LWR_CLEAR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          status_nxt   = ST_RANGE;
          state_nxt    = S_RESULT;
          priority if (sts.in_op == OP_INSERT) begin
            if (sts.ins_ok && sts.free_empty) begin
              status_nxt = ST_FULL;
            end else if (sts.ins_ok) begin
              status_nxt = ST_OK;
              state_nxt  = S_WALK;
              cmd.lrd    = LRD_HEAD;
            end
          end else if (sts.in_op == OP_DELETE || sts.in_op == OP_READ) begin
            if (sts.acc_ok) begin
              status_nxt = ST_OK;
              state_nxt  = S_WALK;
              cmd.lrd    = LRD_HEAD;
            end
          end else begin
            status_nxt = ST_RANGE;
          end
        end
      end
      S_WALK: begin
        if (!sts.walk_done) begin
          cmd.lrd      = LRD_NEXT;
          cmd.walk_adv = 1'b1;
        end else begin
          cmd.walk_cap = 1'b1;
          priority if (sts.req_op == OP_INSERT) begin
            cmd.lrd        = LRD_FRESH;
            cmd.val_wr     = 1'b1;
            cmd.take_fresh = 1'b1;
            state_nxt      = S_INS_B;
          end else if (sts.req_op == OP_DELETE) begin
            cmd.lrd   = LRD_NEXT;
            state_nxt = S_DEL_B;
          end else begin
            cmd.val_rd = 1'b1;
            state_nxt  = S_RESULT;
          end
        end
      end
      S_INS_B: begin
        cmd.free_pop = 1'b1;
        cmd.lwr      = LWR_FRESH;
        state_nxt    = S_INS_C;
      end
      S_INS_C: begin
        cmd.lwr     = LWR_PREV_FRESH;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_DEL_B: begin
        cmd.lwr   = LWR_PREV_SKIP;
        state_nxt = S_DEL_C;
      end
      S_DEL_C: begin
        cmd.lwr       = LWR_GONE;
        cmd.free_push = 1'b1;
        cmd.cnt_dec   = 1'b1;
        state_nxt     = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/core/slle_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the static linked list engine: slot stores, walk and result registers.
module slle_dp
  import slle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_data,
  input  logic      out_ready,
  output logic      out_valid,
  output out_rsp_t  out_data,
  input  slle_cmd_t cmd,
  output slle_sts_t sts
);

  logic [SLOT_W-1:0] link_mem [SLOTS];
  logic [VAL_W-1:0]  value_mem [SLOTS];

  logic [SLOT_W-1:0] link_rdata_r;
  logic [VAL_W-1:0]  value_rdata_r;
  logic [SLOT_W-1:0] clr_idx_r, clr_idx_nxt;
  logic [SLOT_W-1:0] free_head_r, free_head_nxt;
  logic [LEN_W-1:0]  count_r, count_nxt;
  logic [SLOT_W-1:0] cur_r;
  logic [SLOT_W-1:0] nxt_r;
  logic [SLOT_W-1:0] fresh_r;
  logic [POS_W-1:0]  steps_r;
  in_req_t           req_r;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_r;

  logic              lrd_en;
  logic [SLOT_W-1:0] lrd_addr;
  logic              lwr_en;
  logic [SLOT_W-1:0] lwr_addr;
  logic [SLOT_W-1:0] lwr_data;
  logic              pos_nz;

  // Link read address
  always_comb begin
    lrd_en   = 1'b1;
    lrd_addr = LIST_HEAD;
    unique case (cmd.lrd)
      LRD_NONE:  lrd_en   = 1'b0;
      LRD_HEAD:  lrd_addr = LIST_HEAD;
      LRD_NEXT:  lrd_addr = link_rdata_r;
      LRD_FRESH: lrd_addr = free_head_r;
      default:   lrd_en   = 1'b0;
    endcase
  end

  // Link write address and data
  always_comb begin
    lwr_en   = 1'b1;
    lwr_addr = clr_idx_r;
    lwr_data = '0;
    unique case (cmd.lwr)
      LWR_NONE: lwr_en = 1'b0;
      LWR_CLEAR: begin
        lwr_addr = clr_idx_r;
        lwr_data = (clr_idx_r < LAST_DATA) ? clr_idx_r + FIRST_DATA : FREE_HEAD;
      end
      LWR_FRESH: begin
        lwr_addr = fresh_r;
        lwr_data = nxt_r;
      end
      LWR_PREV_FRESH: begin
        lwr_addr = cur_r;
        lwr_data = fresh_r;
      end
      LWR_PREV_SKIP: begin
        lwr_addr = cur_r;
        lwr_data = link_rdata_r;
      end
      LWR_GONE: begin
        lwr_addr = nxt_r;
        lwr_data = free_head_r;
      end
      default: lwr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lwr_en) begin
      link_mem[lwr_addr] <= lwr_data;
    end
    if (lrd_en) begin
      link_rdata_r <= link_mem[lrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.val_wr) begin
      value_mem[free_head_r] <= req_r.new_value;
    end
    if (cmd.val_rd) begin
      value_rdata_r <= value_mem[link_rdata_r];
    end
  end

  always_comb begin
    clr_idx_nxt = clr_idx_r;
    if (cmd.lwr == LWR_CLEAR) begin
      clr_idx_nxt = clr_idx_r + FIRST_DATA;
    end
    free_head_nxt = free_head_r;
    if (cmd.free_pop) begin
      free_head_nxt = link_rdata_r;
    end else if (cmd.free_push) begin
      free_head_nxt = nxt_r;
    end
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + LEN_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - LEN_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      free_head_r <= FIRST_DATA;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_idx_r   <= clr_idx_nxt;
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk registers: cur_r is the slot whose link sits in link_rdata_r
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r   <= in_data;
      steps_r <= in_data.position - POS_W'(1);
    end else if (cmd.walk_adv) begin
      steps_r <= steps_r - POS_W'(1);
    end
    if (cmd.lrd == LRD_HEAD) begin
      cur_r <= LIST_HEAD;
    end else if (cmd.walk_adv) begin
      cur_r <= link_rdata_r;
    end
    if (cmd.walk_cap) begin
      nxt_r <= link_rdata_r;
    end
    if (cmd.take_fresh) begin
      fresh_r <= free_head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status      <= cmd.out_status;
      out_r.read_value  <= (cmd.out_status == ST_OK && req_r.operation == OP_READ) ?
                           value_rdata_r : '0;
      out_r.list_length <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pos_nz = (in_data.position != '0);

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_idx_r == LIST_HEAD);
    sts.walk_done  = (steps_r == '0);
    sts.free_empty = (free_head_r == FREE_HEAD);
    sts.ins_ok     = pos_nz &&
                     ({1'b0, in_data.position} <= ({1'b0, count_r} + (LEN_W + 1)'(1)));
    sts.acc_ok     = pos_nz && (in_data.position <= count_r);
    sts.out_busy   = out_valid_r && !out_ready;
    sts.in_op      = in_data.operation;
    sts.req_op     = req_r.operation;
  end

endmodule

// ----- rtl/core/static_linked_list_engine_unit.sv -----
`timescale 1ns / 1ps
// Top level of the static linked list engine.
//
// A list of up to 1022 signed 32-bit values lives in a store of 1024 slots.
// Slot 0 ends the chain of free slots; slot 1023 heads the list.
// Input channel (in_valid/in_ready/in_data): one request inserts a value before
// a one-based position, deletes the element at a position, or reads it.
// Result channel (out_valid/out_ready/out_data): exactly one result per request
// with a status (ok, position out of range, no free slot), the value read and
// the list length after the request.
// Timing: a request walks the links from the list head, one slot per cycle
// over the single read port of the link store. A valid read then goes to the
// result state, an insert or delete first through its splice states (S_INS_B,
// S_INS_C or S_DEL_B, S_DEL_C); a rejected request goes straight to the result
// state. One request is worked on at a time.
// Reset: rst_n is synchronous. After reset a clearing pass writes the free
// chain into all 1024 slots of the link store, with in_ready held low.
// Stall: the result sits in an output register; a new request is taken while
// it waits, but the next result holds in the controller until out_ready frees
// the register.
module static_linked_list_engine_unit
  import slle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  slle_cmd_t cmd;
  slle_sts_t sts;

  // Sequence each request: range check, walk, splice for insert and delete, result hand-off
  slle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the slot stores, the free head, the count and the result register
  slle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
